FILE: hdl/chip8_instruction_executor_unit_assert.svh
// Assertion macros for the CHIP-8 executor.
`ifndef CHIP8_INSTRUCTION_EXECUTOR_UNIT_ASSERT_SVH
`define CHIP8_INSTRUCTION_EXECUTOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked only out of reset
`define C8X_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked on every edge
`define C8X_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define C8X_ASSERT(lbl, prop, msg)
`define C8X_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hdl/c8x_pkg.sv
`timescale 1ns / 1ps
package c8x_pkg;

  localparam logic [1:0] OPER_EXEC    = 2'd0;
  localparam logic [1:0] OPER_LOAD    = 2'd1;
  localparam logic [1:0] OPER_COLLIDE = 2'd2;

  localparam logic [1:0] DISP_NONE  = 2'd0;
  localparam logic [1:0] DISP_CLEAR = 2'd1;
  localparam logic [1:0] DISP_DRAW  = 2'd2;

  localparam logic [1:0] TMR_NONE  = 2'd0;
  localparam logic [1:0] TMR_DELAY = 2'd1;
  localparam logic [1:0] TMR_SOUND = 2'd2;

  localparam logic [1:0] FLT_NONE  = 2'd0;
  localparam logic [1:0] FLT_OVER  = 2'd1;
  localparam logic [1:0] FLT_UNDER = 2'd2;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;
  localparam logic [11:0] ADDR_MAX = 12'hFFF;

  localparam logic [7:0] KK_SKP  = 8'h9E;
  localparam logic [7:0] KK_SKNP = 8'hA1;
  localparam logic [7:0] FX_GETDT = 8'h07;
  localparam logic [7:0] FX_WAITK = 8'h0A;
  localparam logic [7:0] FX_SETDT = 8'h15;
  localparam logic [7:0] FX_SETST = 8'h18;
  localparam logic [7:0] FX_ADDI  = 8'h1E;
  localparam logic [7:0] FX_FONT  = 8'h29;
  localparam logic [7:0] FX_BCD   = 8'h33;
  localparam logic [7:0] FX_STORE = 8'h55;
  localparam logic [7:0] FX_LOAD  = 8'h65;

  typedef enum logic [3:0] {
    S_IDLE, S_RX, S_RY, S_R0, S_EXEC, S_WX, S_WF,
    S_BCD, S_STR, S_STW, S_LDR, S_LDW, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    MOP_NONE, MOP_BCD, MOP_STORE, MOP_LOAD
  } memop_t;

endpackage

FILE: hdl/c8x_ram.sv
`timescale 1ns / 1ps
module c8x_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/chip8_instruction_executor_unit.sv
`timescale 1ns / 1ps
// CHIP-8 instruction executor.
// Input channel (in_*): one item per transfer. in_operation selects execute
// opcode, load one memory byte, or write the display's collision bit to VF.
// Result channel (out_*): exactly one result per input item, in order:
// next PC, jump/key-wait flags, display command with sprite fields, timer
// write and stack fault.
// Steps: a load/collision item goes straight to its result. An opcode does
// three register file reads through the single read port, execute and result,
// plus one write state per register write (Vx, VF), three byte writes for
// Fx33, and for Fx55/Fx65 a read state and a write state for each of the x+1
// bytes moved between the register file and main memory.
// One item is worked on at a time; in_ready is high only while idle.
// A finished result waits in an output register; if the receiver stalls, the
// next result is held in the core until out_ready frees the register.
// Reset (rst_n low, synchronous): V0..VF zero, I zero, PC 512, stack empty.
// V0..VF live in a 16x8 RAM that reset does not touch, so they are marked by
// per-register valid bits; main memory and the return stack are RAMs whose
// contents are undefined until written.
module chip8_instruction_executor_unit
  import c8x_pkg::*;
#(
  parameter int MEM_BYTES   = 4096,
  parameter int STACK_DEPTH = 16,
  parameter int FONT_BASE   = 80
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_opcode,
  input  logic [7:0]  in_random_byte,
  input  logic [15:0] in_keys_down,
  input  logic [7:0]  in_delay_timer_now,
  input  logic [11:0] in_load_address,
  input  logic [7:0]  in_load_byte,
  input  logic        in_collision,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_next_pc,
  output logic        out_jumped,
  output logic        out_waiting_for_key,
  output logic [1:0]  out_display_command,
  output logic [11:0] out_sprite_address,
  output logic [7:0]  out_sprite_x,
  output logic [7:0]  out_sprite_y,
  output logic [3:0]  out_sprite_rows,
  output logic [1:0]  out_timer_write,
  output logic [7:0]  out_timer_value,
  output logic [1:0]  out_fault
);

`include "chip8_instruction_executor_unit_assert.svh"

  localparam int MAW = $clog2(MEM_BYTES);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SLW = $clog2(STACK_DEPTH + 1);
  localparam logic [SLW-1:0] SlvlFull = SLW'(STACK_DEPTH);
  localparam logic [11:0] FontBase = 12'(FONT_BASE);

  state_t state_r, state_nxt;

  // architectural state in flops
  logic [11:0]    pc_r, idx_r;
  logic [SLW-1:0] lvl_r;
  logic [15:0]    vvalid_r;   // V register written since reset

  // latched item
  logic [15:0] op_r, keys_r;
  logic [7:0]  rnd_r, dt_r;
  logic [7:0]  vx_r, vy_r;

  // write-back plan from execute
  logic        wf_en_r;
  logic [7:0]  wx_data_r, wf_data_r;
  memop_t      mop_r;
  logic [3:0]  cnt_r;
  logic [3:0]  bh_r, bt_r, bo_r;

  // pending result
  logic [11:0] p_pc_r, p_saddr_r;
  logic        p_jmp_r, p_wait_r;
  logic [1:0]  p_disp_r, p_tw_r, p_flt_r;
  logic [7:0]  p_sx_r, p_sy_r, p_tv_r;
  logic [3:0]  p_rows_r;

  // output register
  logic        ov_r;
  logic [11:0] o_pc_r, o_saddr_r;
  logic        o_jmp_r, o_wait_r;
  logic [1:0]  o_disp_r, o_tw_r, o_flt_r;
  logic [7:0]  o_sx_r, o_sy_r, o_tv_r;
  logic [3:0]  o_rows_r;

  // RAM ports
  logic           rf_we;
  logic [3:0]     rf_waddr, rf_raddr;
  logic [7:0]     rf_wdata, rf_rdata, rf_val;
  logic [3:0]     rf_raddr_q;
  logic           mm_we;
  logic [MAW-1:0] mm_waddr, mm_raddr;
  logic [7:0]     mm_wdata, mm_rdata;
  logic           st_we;
  logic [SAW-1:0] st_waddr, st_raddr;
  logic [11:0]    st_rdata;
  logic [SLW-1:0] lvl_m1;

  logic        acc;
  logic        out_free;
  logic [3:0]  ox, oy, on;
  logic [7:0]  kk;
  logic [11:0] nnn, i_plus;

  // execute results
  logic [11:0]    nx_pc, nx_idx, nx_saddr;
  logic [SLW-1:0] nx_lvl;
  logic           nx_jmp, nx_wait, nx_push, wx_en, wf_en;
  logic [1:0]     nx_disp, nx_tw, nx_flt;
  logic [7:0]     nx_sx, nx_sy, nx_tv, wx_data, wf_data;
  logic [3:0]     nx_rows;
  memop_t         nx_mop;
  logic [12:0]    sum_i;
  logic [8:0]     sum_v;
  logic [11:0]    adv;
  logic           kp;
  logic [3:0]     first_key;
  logic           any_key;
  logic [1:0]     bcd_h;
  logic [6:0]     bcd_rem;
  logic [14:0]    bcd_mul;
  logic [3:0]     bcd_t;
  logic [6:0]     bcd_o;

  assign acc      = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !ov_r || out_ready;
  assign ox  = op_r[11:8];
  assign oy  = op_r[7:4];
  assign on  = op_r[3:0];
  assign kk  = op_r[7:0];
  assign nnn = op_r[11:0];
  assign i_plus = idx_r + {8'd0, cnt_r};
  assign lvl_m1 = lvl_r - SLW'(1);
  // unwritten V registers read as zero
  assign rf_val = vvalid_r[rf_raddr_q] ? rf_rdata : 8'd0;

  c8x_ram #(.WIDTH(8), .DEPTH(16)) u_regs (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_raddr), .rdata(rf_rdata)
  );

  c8x_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk(clk), .we(mm_we), .waddr(mm_waddr), .wdata(mm_wdata),
    .raddr(mm_raddr), .rdata(mm_rdata)
  );

  c8x_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(pc_r),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  // ---------------- execute (state S_EXEC) ----------------
  always_comb begin
    kp = (vx_r <= 8'd15) && keys_r[vx_r[3:0]];
    first_key = 4'd0;
    any_key = 1'b0;
    for (int k = 15; k >= 0; k--) begin
      if (keys_r[k]) begin
        first_key = 4'(k);
        any_key = 1'b1;
      end
    end
    sum_i = {1'b0, idx_r} + {5'd0, vx_r};
    sum_v = {1'b0, vx_r} + {1'b0, vy_r};
    bcd_h = (vx_r >= 8'd200) ? 2'd2 : ((vx_r >= 8'd100) ? 2'd1 : 2'd0);
    bcd_rem = 7'(vx_r - 8'(bcd_h) * 8'd100);
    bcd_mul = {8'd0, bcd_rem} * 15'd205;
    bcd_t = bcd_mul[14:11];
    bcd_o = bcd_rem - 7'(bcd_t) * 7'd10;

    adv = 12'd2;
    nx_jmp = 1'b0; nx_wait = 1'b0; nx_push = 1'b0;
    nx_pc = pc_r; nx_idx = idx_r; nx_lvl = lvl_r;
    nx_disp = DISP_NONE; nx_saddr = 12'd0; nx_sx = 8'd0; nx_sy = 8'd0;
    nx_rows = 4'd0; nx_tw = TMR_NONE; nx_tv = 8'd0; nx_flt = FLT_NONE;
    wx_en = 1'b0; wx_data = 8'd0; wf_en = 1'b0; wf_data = 8'd0;
    nx_mop = MOP_NONE;

    case (op_r[15:12])
      4'h0: begin
        if (op_r == OP_CLS) begin
          nx_disp = DISP_CLEAR;
        end else if (op_r == OP_RET) begin
          if (lvl_r == '0) begin
            nx_flt = FLT_UNDER;
          end else begin
            nx_lvl = lvl_m1;
            nx_pc = st_rdata + 12'd2;
            nx_jmp = 1'b1;
          end
        end
      end
      4'h1: begin
        nx_pc = nnn; nx_jmp = 1'b1;
      end
      4'h2: begin
        if (lvl_r >= SlvlFull) begin
          nx_flt = FLT_OVER;
        end else begin
          nx_push = 1'b1;
          nx_lvl = lvl_r + SLW'(1);
          nx_pc = nnn; nx_jmp = 1'b1;
        end
      end
      4'h3: if (vx_r == kk) adv = 12'd4;
      4'h4: if (vx_r != kk) adv = 12'd4;
      4'h5: if (on == 4'd0 && vx_r == vy_r) adv = 12'd4;
      4'h6: begin
        wx_en = 1'b1; wx_data = kk;
      end
      4'h7: begin
        wx_en = 1'b1; wx_data = vx_r + kk;
      end
      4'h8: begin
        case (on)
          4'h0: begin wx_en = 1'b1; wx_data = vy_r; end
          4'h1: begin wx_en = 1'b1; wx_data = vx_r | vy_r; wf_en = 1'b1; end
          4'h2: begin wx_en = 1'b1; wx_data = vx_r & vy_r; wf_en = 1'b1; end
          4'h3: begin wx_en = 1'b1; wx_data = vx_r ^ vy_r; wf_en = 1'b1; end
          4'h4: begin
            wx_en = 1'b1; wx_data = sum_v[7:0];
            wf_en = 1'b1; wf_data = {7'd0, sum_v[8]};
          end
          4'h5: begin
            wx_en = 1'b1; wx_data = vx_r - vy_r;
            wf_en = 1'b1; wf_data = {7'd0, vx_r >= vy_r};
          end
          4'h6: begin
            wx_en = 1'b1; wx_data = {1'b0, vx_r[7:1]};
            wf_en = 1'b1; wf_data = {7'd0, vx_r[0]};
          end
          4'h7: begin
            wx_en = 1'b1; wx_data = vy_r - vx_r;
            wf_en = 1'b1; wf_data = {7'd0, vy_r >= vx_r};
          end
          4'hE: begin
            wx_en = 1'b1; wx_data = {vx_r[6:0], 1'b0};
            wf_en = 1'b1; wf_data = {7'd0, vx_r[7]};
          end
          default: ;
        endcase
      end
      4'h9: if (on == 4'd0 && vx_r != vy_r) adv = 12'd4;
      4'hA: nx_idx = nnn;
      4'hB: begin
        nx_pc = nnn + {4'd0, rf_val}; nx_jmp = 1'b1;
      end
      4'hC: begin
        wx_en = 1'b1; wx_data = rnd_r & kk;
      end
      4'hD: begin
        nx_disp = DISP_DRAW; nx_saddr = idx_r;
        nx_sx = vx_r; nx_sy = vy_r; nx_rows = on;
      end
      4'hE: begin
        if (kk == KK_SKP) begin
          if (kp) adv = 12'd4;
        end else if (kk == KK_SKNP) begin
          if (!kp) adv = 12'd4;
        end
      end
      default: begin
        case (kk)
          FX_GETDT: begin wx_en = 1'b1; wx_data = dt_r; end
          FX_WAITK: begin
            if (!any_key) begin
              nx_wait = 1'b1; adv = 12'd0;
            end else begin
              wx_en = 1'b1; wx_data = {4'd0, first_key};
            end
          end
          FX_SETDT: begin nx_tw = TMR_DELAY; nx_tv = vx_r; end
          FX_SETST: begin nx_tw = TMR_SOUND; nx_tv = vx_r; end
          FX_ADDI: begin
            nx_idx = sum_i[11:0];
            wf_en = 1'b1; wf_data = {7'd0, sum_i[12]};
          end
          FX_FONT: nx_idx = FontBase + {8'd0, vx_r[3:0]} * 12'd5;
          FX_BCD:   nx_mop = MOP_BCD;
          FX_STORE: nx_mop = MOP_STORE;
          FX_LOAD:  nx_mop = MOP_LOAD;
          default: ;
        endcase
      end
    endcase
    if (!nx_jmp) begin
      nx_pc = pc_r + adv;
    end
  end

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (acc) state_nxt = (in_operation == OPER_EXEC) ? S_RX : S_DONE;
      S_RX:   state_nxt = S_RY;
      S_RY:   state_nxt = S_R0;
      S_R0:   state_nxt = S_EXEC;
      S_EXEC: begin
        if (wx_en) begin
          state_nxt = S_WX;
        end else if (wf_en) begin
          state_nxt = S_WF;
        end else begin
          case (nx_mop)
            MOP_BCD:   state_nxt = S_BCD;
            MOP_STORE: state_nxt = S_STR;
            MOP_LOAD:  state_nxt = S_LDR;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_WX:  state_nxt = wf_en_r ? S_WF : S_DONE;
      S_WF:  state_nxt = S_DONE;
      S_BCD: if (cnt_r == 4'd2) state_nxt = S_DONE;
      S_STR: state_nxt = S_STW;
      S_STW: state_nxt = (cnt_r == ox) ? S_DONE : S_STR;
      S_LDR: state_nxt = S_LDW;
      S_LDW: state_nxt = (cnt_r == ox) ? S_DONE : S_LDR;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------- RAM control ----------------
  always_comb begin
    rf_we = 1'b0; rf_waddr = 4'd0; rf_wdata = 8'd0; rf_raddr = 4'd0;
    mm_we = 1'b0; mm_waddr = i_plus[MAW-1:0]; mm_wdata = 8'd0;
    mm_raddr = i_plus[MAW-1:0];
    st_we = 1'b0;
    st_waddr = lvl_r[SAW-1:0];
    st_raddr = lvl_m1[SAW-1:0];
    case (state_r)
      S_IDLE: begin
        if (acc && in_operation == OPER_LOAD) begin
          mm_we = 1'b1; mm_waddr = in_load_address[MAW-1:0];
          mm_wdata = in_load_byte;
        end
        if (acc && in_operation == OPER_COLLIDE) begin
          rf_we = 1'b1; rf_waddr = 4'hF; rf_wdata = {7'd0, in_collision};
        end
      end
      S_RX: rf_raddr = ox;
      S_RY: rf_raddr = oy;
      S_R0: rf_raddr = 4'd0;
      S_EXEC: st_we = nx_push;
      S_WX: begin rf_we = 1'b1; rf_waddr = ox; rf_wdata = wx_data_r; end
      S_WF: begin rf_we = 1'b1; rf_waddr = 4'hF; rf_wdata = wf_data_r; end
      S_BCD: begin
        mm_we = 1'b1;
        case (cnt_r)
          4'd0:    mm_wdata = {4'd0, bh_r};
          4'd1:    mm_wdata = {4'd0, bt_r};
          default: mm_wdata = {4'd0, bo_r};
        endcase
      end
      S_STR: rf_raddr = cnt_r;
      S_STW: begin mm_we = 1'b1; mm_wdata = rf_val; end
      S_LDW: begin rf_we = 1'b1; rf_waddr = cnt_r; rf_wdata = mm_rdata; end
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pc_r     <= 12'd512;
      idx_r    <= 12'd0;
      lvl_r    <= '0;
      vvalid_r <= 16'd0;
      ov_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (rf_we) begin
        vvalid_r[rf_waddr] <= 1'b1;
      end
      if (state_r == S_EXEC) begin
        pc_r  <= nx_pc;
        idx_r <= nx_idx;
        lvl_r <= nx_lvl;
      end
      if (state_r == S_DONE && out_free) begin
        ov_r <= 1'b1;
      end else if (ov_r && out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rf_raddr_q <= rf_raddr;
    if (acc) begin
      op_r   <= in_opcode;
      keys_r <= in_keys_down;
      rnd_r  <= in_random_byte;
      dt_r   <= in_delay_timer_now;
      cnt_r  <= 4'd0;
      // non-execute items report the current PC and nothing else
      p_pc_r <= pc_r; p_jmp_r <= 1'b0; p_wait_r <= 1'b0;
      p_disp_r <= DISP_NONE; p_saddr_r <= 12'd0; p_sx_r <= 8'd0;
      p_sy_r <= 8'd0; p_rows_r <= 4'd0; p_tw_r <= TMR_NONE;
      p_tv_r <= 8'd0; p_flt_r <= FLT_NONE;
    end
    if (state_r == S_RY) vx_r <= rf_val;
    if (state_r == S_R0) vy_r <= rf_val;
    if (state_r == S_EXEC) begin
      wf_en_r <= wf_en; wx_data_r <= wx_data; wf_data_r <= wf_data;
      mop_r <= nx_mop;
      bh_r <= {2'd0, bcd_h}; bt_r <= bcd_t; bo_r <= bcd_o[3:0];
      p_pc_r <= nx_pc; p_jmp_r <= nx_jmp; p_wait_r <= nx_wait;
      p_disp_r <= nx_disp; p_saddr_r <= nx_saddr; p_sx_r <= nx_sx;
      p_sy_r <= nx_sy; p_rows_r <= nx_rows; p_tw_r <= nx_tw;
      p_tv_r <= nx_tv; p_flt_r <= nx_flt;
    end
    if (state_r == S_BCD || state_r == S_STW || state_r == S_LDW) begin
      cnt_r <= cnt_r + 4'd1;
    end
    if (state_r == S_DONE && out_free) begin
      o_pc_r <= p_pc_r; o_jmp_r <= p_jmp_r; o_wait_r <= p_wait_r;
      o_disp_r <= p_disp_r; o_saddr_r <= p_saddr_r; o_sx_r <= p_sx_r;
      o_sy_r <= p_sy_r; o_rows_r <= p_rows_r; o_tw_r <= p_tw_r;
      o_tv_r <= p_tv_r; o_flt_r <= p_flt_r;
    end
  end

  assign out_valid           = ov_r;
  assign out_next_pc         = o_pc_r;
  assign out_jumped          = o_jmp_r;
  assign out_waiting_for_key = o_wait_r;
  assign out_display_command = o_disp_r;
  assign out_sprite_address  = o_saddr_r;
  assign out_sprite_x        = o_sx_r;
  assign out_sprite_y        = o_sy_r;
  assign out_sprite_rows     = o_rows_r;
  assign out_timer_write     = o_tw_r;
  assign out_timer_value     = o_tv_r;
  assign out_fault           = o_flt_r;

  // memory sequences only start from execute with a matching plan
  `C8X_ASSERT(a_mop_seq, (state_r == S_STR || state_r == S_LDR || state_r == S_BCD) |-> (mop_r != MOP_NONE), "memory walk without a planned memory op")
  `C8X_ASSERT(a_stack_lvl, lvl_r <= SlvlFull, "stack level beyond depth")
  `C8X_ASSERT(a_busy, acc |=> !in_ready, "accepted a second item while busy")
  `C8X_ASSERT(a_publish, (state_r == S_DONE && out_free) |=> out_valid, "result not published")
  `C8X_ASSERT_ALWAYS(a_rst, !rst_n |=> (state_r == S_IDLE && !ov_r), "reset left block busy")

endmodule
